// ===== rtl/core/swm_pkg.sv =====
package swm_pkg;

  // width of the window size register
  localparam int CfgWidth = 6;

  // window size after reset
  localparam logic [CfgWidth-1:0] WindowReset = 6'd3;

  // per-cycle command shared by every cell of the sorted chain
  typedef struct packed {
    logic item;   // a sample transfer happens this cycle
    logic first;  // the sample starts a new sequence
    logic purge;  // remove the first entry older than the window
  } cell_ctrl_t;

endpackage

// ===== rtl/core/swm_in_if.sv =====
interface swm_in_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] sample;
  logic                first_sample;

  modport source (output valid, output sample, output first_sample, input ready);
  modport sink   (input valid, input sample, input first_sample, output ready);
endinterface

// ===== rtl/core/swm_out_if.sv =====
interface swm_out_if #(
  parameter int W = 32
);
  logic                valid;
  logic                ready;
  logic signed [W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

// ===== rtl/core/swm_cell.sv =====
module swm_cell #(
  parameter int SW = 32,
  parameter int AW = 5,
  parameter int WW = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  swm_pkg::cell_ctrl_t  ctrl,
  input  logic [WW-1:0]        wsize,
  input  logic signed [SW-1:0] key,
  // removal ripple from the left
  input  logic                 prefix_in,
  output logic                 prefix_out,
  // stored entry of the right neighbor
  input  logic                 right_valid,
  input  logic [AW-1:0]        right_age,
  input  logic signed [SW-1:0] right_value,
  // compacted entry of the left neighbor
  input  logic                 left_valid,
  input  logic [AW-1:0]        left_age,
  input  logic signed [SW-1:0] left_value,
  input  logic                 left_gt,
  // compacted entry handed to the right neighbor
  output logic                 c_valid,
  output logic [AW-1:0]        c_age,
  output logic signed [SW-1:0] c_value,
  output logic                 c_gt,
  // stored entry
  output logic                 ent_valid,
  output logic [AW-1:0]        ent_age,
  output logic signed [SW-1:0] ent_value,
  output logic                 stale
);

  logic                 valid_r, valid_nxt;
  logic [AW-1:0]        age_r, age_nxt;
  logic signed [SW-1:0] value_r, value_nxt;
  logic                 cand;
  logic                 shift;
  logic                 src_valid;
  logic [AW-1:0]        src_age;
  logic signed [SW-1:0] src_value;

  // entry older than the window, left over from a window shrink
  assign stale = valid_r && (WW'(age_r) >= wsize);

  // this entry leaves the window
  always_comb begin
    cand = 1'b0;
    if (ctrl.item) begin
      cand = valid_r && ((WW'(age_r) + WW'(1)) >= wsize);
    end else if (ctrl.purge) begin
      cand = stale;
    end
  end

  // once a removal is seen at or left of here, take the right neighbor
  assign shift      = prefix_in | cand;
  assign prefix_out = shift;

  assign src_valid = shift ? right_valid : valid_r;
  assign src_age   = shift ? right_age   : age_r;
  assign src_value = shift ? right_value : value_r;

  // compacted and aged entry
  assign c_valid = src_valid && !(ctrl.item && ctrl.first);
  assign c_age   = ctrl.item ? (src_age + AW'(1)) : src_age;
  assign c_value = src_value;
  assign c_gt    = !c_valid || (c_value > key);

  // insertion: entries above the key move one place right
  always_comb begin
    valid_nxt = c_valid;
    age_nxt   = c_age;
    value_nxt = c_value;
    if (ctrl.item && c_gt) begin
      if (left_gt) begin
        valid_nxt = left_valid;
        age_nxt   = left_age;
        value_nxt = left_value;
      end else begin
        valid_nxt = 1'b1;
        age_nxt   = '0;
        value_nxt = key;
      end
    end
  end

  // valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    age_r   <= age_nxt;
    value_r <= value_nxt;
  end

  assign ent_valid = valid_r;
  assign ent_age   = age_r;
  assign ent_value = value_r;

endmodule

// ===== rtl/core/sliding_window_median.sv =====
// channel  | direction | payload                         | transfer
// in_ch    | sink      | sample, first_sample            | valid && ready
// out_ch   | source    | median (lower median of window) | valid && ready
// cfg      | write     | cfg_data = window size          | cfg_we
//
// one sample per cycle: the chain of MAX_WINDOW cells inserts and expires in the transfer cycle
// the median goes from the chain into the output register once pending_r is set and the output register is free
// after a window shrink, each entry older than the window is removed by a purge of its own,
// with in_ch.ready held low meanwhile
// in_ch.ready is also low while a result waits behind a full output register
// reset is synchronous and empties the window
module sliding_window_median #(
  parameter int MAX_WINDOW   = 32,
  parameter int SAMPLE_WIDTH = 32
) (
  input  logic                             clk,
  input  logic                             rst_n,
  swm_in_if.sink                           in_ch,
  swm_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [swm_pkg::CfgWidth-1:0]     cfg_data
);

  localparam int N  = MAX_WINDOW;
  localparam int SW = SAMPLE_WIDTH;
  localparam int AW = (N > 1) ? $clog2(N) : 1;
  localparam int WW = $clog2(N + 1);

  logic [swm_pkg::CfgWidth-1:0] cfg_r;
  logic [WW-1:0]                fill_r, fill_nxt;
  logic                         pending_r;
  logic [AW-1:0]                med_idx_r;
  logic                         out_valid_r;
  logic signed [SW-1:0]         out_median_r;

  logic [WW-1:0]         wsize;
  swm_pkg::cell_ctrl_t   ctrl;
  logic                  accept;
  logic                  out_free;
  logic                  stale_any;
  logic                  emit;

  logic                 prefix [0:N];
  logic                 c_valid [0:N];
  logic [AW-1:0]        c_age [0:N];
  logic signed [SW-1:0] c_value [0:N];
  logic                 c_gt [0:N];
  logic                 e_valid [0:N];
  logic [AW-1:0]        e_age [0:N];
  logic signed [SW-1:0] e_value [0:N];
  logic [N-1:0]         stale_vec;
  logic [N-1:0]         valid_vec;

  // effective window size
  always_comb begin
    if (cfg_r == '0) begin
      wsize = WW'(1);
    end else if (int'(cfg_r) > N) begin
      wsize = WW'(N);
    end else begin
      wsize = WW'(cfg_r);
    end
  end

  // handshakes
  assign stale_any   = |stale_vec;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !stale_any && (!pending_r || out_free);
  assign accept      = in_ch.valid && in_ch.ready;

  assign ctrl.item  = accept;
  assign ctrl.first = in_ch.first_sample;
  assign ctrl.purge = stale_any && !pending_r;

  // chain ends
  assign prefix[0]  = 1'b0;
  assign c_valid[0] = 1'b0;
  assign c_age[0]   = '0;
  assign c_value[0] = '0;
  assign c_gt[0]    = 1'b0;
  assign e_valid[N] = 1'b0;
  assign e_age[N]   = '0;
  assign e_value[N] = '0;

  // sorted chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    swm_cell #(.SW(SW), .AW(AW), .WW(WW)) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .wsize       (wsize),
      .key         (in_ch.sample),
      .prefix_in   (prefix[i]),
      .prefix_out  (prefix[i+1]),
      .right_valid (e_valid[i+1]),
      .right_age   (e_age[i+1]),
      .right_value (e_value[i+1]),
      .left_valid  (c_valid[i]),
      .left_age    (c_age[i]),
      .left_value  (c_value[i]),
      .left_gt     (c_gt[i]),
      .c_valid     (c_valid[i+1]),
      .c_age       (c_age[i+1]),
      .c_value     (c_value[i+1]),
      .c_gt        (c_gt[i+1]),
      .ent_valid   (e_valid[i]),
      .ent_age     (e_age[i]),
      .ent_value   (e_value[i]),
      .stale       (stale_vec[i])
    );
    assign valid_vec[i] = e_valid[i];
  end

  // fill count after this cycle
  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (in_ch.first_sample) begin
        fill_nxt = WW'(1);
      end else begin
        fill_nxt = fill_r - WW'(prefix[N]) + WW'(1);
      end
    end else if (ctrl.purge) begin
      fill_nxt = fill_r - WW'(1);
    end
  end

  assign emit = (fill_nxt == wsize);

  // control and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r       <= swm_pkg::WindowReset;
      fill_r      <= '0;
      pending_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_data;
      end
      fill_r <= fill_nxt;
      if (accept) begin
        pending_r <= emit;
      end else if (out_free) begin
        pending_r <= 1'b0;
      end
      if (pending_r && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // median rank and value
  always_ff @(posedge clk) begin
    if (accept) begin
      med_idx_r <= AW'((wsize - WW'(1)) >> 1);
    end
    if (pending_r && out_free) begin
      out_median_r <= e_value[WW'(med_idx_r)];
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.median = out_median_r;

`ifndef SYNTH
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(fill_r) <= N)
    else $error("fill count above chain length");

  a_fill_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == int'(fill_r))
    else $error("fill count disagrees with valid cells");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + N'(1)) & valid_vec) == '0)
    else $error("valid cells not packed at the low end");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(pending_r))
    else $error("result shown without a pending median");
`endif

endmodule

// ===== sim/tb_sliding_window_median.sv =====
`timescale 1ns / 100ps

module tb_sliding_window_median;

  localparam int CfgW = swm_pkg::CfgWidth;
  localparam int SampleW = 32;
  localparam int MaxWin = 32;
  localparam int RandomItems = 1700;
  localparam int CalmItems = 200;
  localparam int DrainCycles = 40;
  localparam int WatchdogLimit = 3000;
  localparam logic signed [SampleW-1:0] SampleMax = 32'sh7fffffff;
  localparam logic signed [SampleW-1:0] SampleMin = 32'sh80000000;

  typedef enum logic {ROW_WINDOW, ROW_SAMPLE} row_kind_t;

  typedef struct packed {
    row_kind_t                  kind;
    logic [CfgW-1:0]            window;
    logic signed [SampleW-1:0]  sample;
    logic                       first;
    logic                       pinned;
    logic signed [SampleW-1:0]  median;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgW-1:0] cfg_data;

  swm_in_if #(.W(SampleW)) in_ch ();
  swm_out_if #(.W(SampleW)) out_ch ();

  sliding_window_median #(
    .MAX_WINDOW  (MaxWin),
    .SAMPLE_WIDTH(SampleW)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  // shadow of the sorted chain, ascending, with the age of each entry
  logic signed [SampleW-1:0] chain_val [MaxWin];
  int unsigned chain_age [MaxWin];
  int unsigned chain_fill = 0;
  logic [CfgW-1:0] window_shadow = swm_pkg::WindowReset;

  logic signed [SampleW-1:0] median_q [$];
  int failures = 0;
  bit calm_tail = 1'b0;
  bit row_pin = 1'b0;
  logic signed [SampleW-1:0] row_pin_med = '0;

  // directed rows: window writes and samples, with a typed median where obvious
  script_row_t directed_rows [21] = '{
    '{ROW_SAMPLE, 6'd0, 32'sd5, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, -32'sd7, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, 32'sd100, 1'b0, 1'b1, 32'sd5},
    '{ROW_SAMPLE, 6'd0, 32'sd0, 1'b0, 1'b1, 32'sd0},
    '{ROW_WINDOW, 6'd1, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, SampleMax, 1'b0, 1'b1, SampleMax},
    '{ROW_SAMPLE, 6'd0, SampleMin, 1'b0, 1'b1, SampleMin},
    '{ROW_SAMPLE, 6'd0, -32'sd1, 1'b1, 1'b1, -32'sd1},
    '{ROW_WINDOW, 6'd0, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, 32'sh12345678, 1'b0, 1'b1, 32'sh12345678},
    '{ROW_SAMPLE, 6'd0, -32'sd2, 1'b0, 1'b1, -32'sd2},
    '{ROW_WINDOW, 6'd2, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, SampleMax, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, SampleMin, 1'b0, 1'b1, SampleMin},
    '{ROW_SAMPLE, 6'd0, SampleMin, 1'b0, 1'b1, SampleMin},
    '{ROW_SAMPLE, 6'd0, 32'sd7, 1'b0, 1'b1, SampleMin},
    '{ROW_WINDOW, 6'd4, '0, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, 32'sd3, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, 32'sd3, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, -32'sd5, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, 6'd0, 32'sd0, 1'b0, 1'b0, '0}
  };

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // lower median of the window after taking one sample, 1 when the window is full
  function automatic bit predict_median(input logic signed [SampleW-1:0] value,
                                        input logic first,
                                        output logic signed [SampleW-1:0] median);
    int unsigned span, kept, pos, i;
    span = (window_shadow == 0) ? 1 : (window_shadow > MaxWin) ? MaxWin : window_shadow;
    if (first) chain_fill = 0;
    kept = 0;
    // age the chain and drop entries that left the window
    for (i = 0; i < chain_fill; i++) begin
      if (chain_age[i] + 1 < span) begin
        chain_val[kept] = chain_val[i];
        chain_age[kept] = chain_age[i] + 1;
        kept++;
      end
    end
    // insert in sorted position
    pos = kept;
    while (pos > 0 && chain_val[pos-1] > value) begin
      chain_val[pos] = chain_val[pos-1];
      chain_age[pos] = chain_age[pos-1];
      pos--;
    end
    chain_val[pos] = value;
    chain_age[pos] = 0;
    chain_fill = kept + 1;
    median = chain_val[(span - 1) / 2];
    return chain_fill == span;
  endfunction

  task automatic log_failure(input string msg);
    failures++;
    if (failures <= 10) $display("%s", msg);
  endtask

  // scoreboard: compare output transfers, then predict from input transfers
  always @(posedge clk) begin : scoreboard
    logic signed [SampleW-1:0] predicted;
    logic signed [SampleW-1:0] want;
    if (rst_n) begin
      if (cfg_we) window_shadow = cfg_data;
      if (out_ch.valid && out_ch.ready) begin
        if (median_q.size() == 0) begin
          log_failure($sformatf("unexpected median %0d", out_ch.median));
        end else begin
          want = median_q.pop_front();
          if (out_ch.median !== want)
            log_failure($sformatf("median mismatch: expected %0d, got %0d",
                                  want, out_ch.median));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        if (predict_median(in_ch.sample, in_ch.first_sample, predicted))
          median_q.insert(median_q.size(), row_pin ? row_pin_med : predicted);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin : watchdog
    int quiet;
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= WatchdogLimit) begin
        $display("sliding_window_median verification failed");
        $finish;
      end
    end
  end

  // result side stalls in bursts, held ready in the calm tail
  always begin : sink_pacing
    int run;
    @(negedge clk);
    if (!calm_tail && $urandom_range(0, 3) == 0) begin
      out_ch.ready <= 1'b0;
      run = $urandom_range(1, 16);
    end else begin
      out_ch.ready <= 1'b1;
      run = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
    end
    repeat (run - 1) @(negedge clk);
  end

  // one sample transfer, entered and left at a falling edge
  task automatic send_sample(input logic signed [SampleW-1:0] value, input logic first,
                             input bit pin, input logic signed [SampleW-1:0] pin_med);
    row_pin = pin;
    row_pin_med = pin_med;
    in_ch.valid <= 1'b1;
    in_ch.sample <= value;
    in_ch.first_sample <= first;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic source_gap(input int cycles);
    in_ch.valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // window write once the block has drained, allowing for purge cycles
  task automatic set_window(input logic [CfgW-1:0] size);
    in_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= size;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [CfgW-1:0] pick_window();
    case ($urandom_range(0, 9))
      0: return 6'd0;
      1: return 6'd1;
      2: return 6'd32;
      3: return 6'd63;
      4: return 6'd2;
      5: return CfgW'($urandom_range(33, 62));
      default: return CfgW'($urandom_range(1, 31));
    endcase
  endfunction

  // mix of full range, tight clusters with ties, and extremes
  function automatic logic signed [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return SampleW'($urandom);
      4, 5, 6: return SampleW'($urandom_range(0, 8) - 4);
      7: begin
        case ($urandom_range(0, 3))
          0: return SampleMax;
          1: return SampleMin;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return SampleW'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  initial begin : stimulus
    int sent, phase_len, gap_odds, k;
    logic first;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.first_sample = 1'b0;
    out_ch.ready = 1'b0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed rows
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WINDOW) begin
        set_window(directed_rows[r].window);
      end else begin
        if ($urandom_range(0, 2) == 0) source_gap($urandom_range(1, 16));
        send_sample(directed_rows[r].sample, directed_rows[r].first,
                    directed_rows[r].pinned, directed_rows[r].median);
      end
    end

    // random phases, each under one window size, mostly continuing the stream
    sent = 0;
    while (sent < RandomItems) begin
      set_window(pick_window());
      phase_len = $urandom_range(40, 160);
      gap_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 8);
      for (k = 0; k < phase_len && sent < RandomItems; k++) begin
        calm_tail = (sent >= RandomItems - CalmItems);
        if (!calm_tail && gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
          source_gap($urandom_range(1, 16));
        first = (k == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 59) == 0);
        send_sample(pick_sample(), first, 1'b0, '0);
        sent++;
      end
    end

    // drain and report
    in_ch.valid <= 1'b0;
    while (median_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    if (failures == 0) begin
      $display("sliding_window_median verification clean");
    end else begin
      $display("sliding_window_median verification failed");
    end
    $finish;
  end

endmodule
